FILE: sv/tdfe_pkg.sv
// Package for the table-driven state machine engine.
// Request/response types, opcodes, status codes and register indexes.
// No dependencies.
`default_nettype none

package tdfe_pkg;

   localparam int STATE_SLOTS_DEF      = 16;
   localparam int TRANSITION_SLOTS_DEF = 64;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_STATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_EVENT = CSR_IDX_W'(1);

   localparam logic [1:0] KIND_ADD_STATE = 2'd0;
   localparam logic [1:0] KIND_ADD_TRANS = 2'd1;
   localparam logic [1:0] KIND_RESET     = 2'd2;
   localparam logic [1:0] KIND_EVENT     = 2'd3;

   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_SAME          = 3'd1;
   localparam logic [2:0] STATUS_NO_MATCH      = 3'd2;
   localparam logic [2:0] STATUS_NEXT_MISSING  = 3'd3;
   localparam logic [2:0] STATUS_RESET_MISSING = 3'd4;
   localparam logic [2:0] STATUS_FULL          = 3'd5;
   localparam logic [2:0] STATUS_NO_CURRENT    = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] state_id;
      logic [7:0] event_id;
      logic [7:0] action_id;
      logic [7:0] next_state_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] transition_action;
      logic [7:0] entry_action;
      logic [7:0] current_state;
      logic       current_valid;
   } rsp_type;

   // compare unit results
   typedef struct packed {
      logic tag_eq;
      logic key_eq;
      logic alt_eq;
   } cmp_type;

endpackage

`default_nettype wire

FILE: sv/tdfe_cmp.sv
// Shared compare unit of the engine: owner tag match plus key and fallback key match.
// Uses tdfe_pkg.
`default_nettype none

module tdfe_cmp #(
   parameter int SW = 4
) (
   input  wire logic [SW-1:0]   tag_a,
   input  wire logic [SW-1:0]   tag_b,
   input  wire logic [7:0]      key,
   input  wire logic [7:0]      probe,
   input  wire logic [7:0]      alt,
   output tdfe_pkg::cmp_type    match
);

   always_comb begin
      match.tag_eq = (tag_a == tag_b);
      match.key_eq = (key == probe);
      // a key equal to the probe never counts as a fallback hit
      match.alt_eq = (key != probe) && (key == alt);
   end

endmodule

`default_nettype wire

FILE: sv/table_driven_fsm_engine.sv
// Table-driven state machine engine, top level.
// Depends on tdfe_pkg and tdfe_cmp.
//
// One request at a time: a request is taken when start is high and busy is low,
// and its single response shows on rsp_item for exactly one cycle with rsp_valid
// high; the receiver cannot stall it, so capture it then. Add-state and
// add-transition answer the cycle after the request. Reset-to-state scans the
// state table. An event scans the transition table through one memory read
// port and one compare unit, once for the default state's transitions (when a
// default state exists) and again for the current state's if that found
// nothing; when a transition is found whose target differs from the current
// state, it then searches the state table for the target. The table memories
// need no clear after reset; the fill counts bound every scan. Configuration
// writes are always accepted (csr_ready is tied high) and should only be made
// while busy is low.
`default_nettype none

module table_driven_fsm_engine #(
   parameter int STATE_SLOTS      = tdfe_pkg::STATE_SLOTS_DEF,
   parameter int TRANSITION_SLOTS = tdfe_pkg::TRANSITION_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire tdfe_pkg::req_type             req_item,
   output      logic                          rsp_valid,
   output      tdfe_pkg::rsp_type             rsp_item,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [tdfe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                    csr_wdata
);

   localparam int SW   = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
   localparam int TW   = (TRANSITION_SLOTS > 1) ? $clog2(TRANSITION_SLOTS) : 1;
   localparam int SCW  = $clog2(STATE_SLOTS + 1);
   localparam int TCW  = $clog2(TRANSITION_SLOTS + 1);
   localparam int MAXS = (STATE_SLOTS > TRANSITION_SLOTS) ? STATE_SLOTS : TRANSITION_SLOTS;
   localparam int CW   = $clog2(MAXS + 1);
   localparam int TEW  = SW + 24;   // owner, event, action, next

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_TSCAN = 2'd1;   // transition table pass
   localparam logic [1:0] ST_PICK  = 2'd2;   // choose hit, same-state check
   localparam logic [1:0] ST_SSCAN = 2'd3;   // state table search by id

   // configuration registers
   logic [7:0] default_state_ff, default_event_ff;

   // machine state
   logic [1:0]     state_ff, state_in;
   logic [SCW-1:0] scount_ff, scount_in;
   logic [TCW-1:0] tcount_ff, tcount_in;
   logic [SW-1:0]  cur_slot_ff, cur_slot_in;
   logic           cur_pres_ff, cur_pres_in;
   logic [7:0]     cur_id_ff, cur_id_in;      // id of current slot, cached
   logic [SW-1:0]  dflt_slot_ff, dflt_slot_in;
   logic           dflt_pres_ff, dflt_pres_in;

   // request being worked on
   tdfe_pkg::req_type req_ff, req_in;

   // scan control
   logic [CW-1:0] iss_ff, iss_in;     // next entry to read
   logic [CW-1:0] q_idx_ff, q_idx_in; // index of entry in read register
   logic          q_vld_ff, q_vld_in;
   logic          phase_ff, phase_in; // 0 default-state pass, 1 current-state pass

   // scan results
   logic       hit_ff, hit_in;
   logic [7:0] h_act_ff, h_act_in, h_next_ff, h_next_in;
   logic       dhit_ff, dhit_in;
   logic [7:0] d_act_ff, d_act_in, d_next_ff, d_next_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] tact_ff, tact_in;
   logic       found_ff, found_in;
   logic [SW-1:0] fslot_ff, fslot_in;
   logic [7:0] fentry_ff, fentry_in;

   // response
   logic              rsp_valid_ff, rsp_valid_in;
   tdfe_pkg::rsp_type rsp_item_ff, rsp_item_in;

   // memories
   logic [15:0]    smem [STATE_SLOTS];
   logic [TEW-1:0] tmem [TRANSITION_SLOTS];
   logic [15:0]    sq_ff;
   logic [TEW-1:0] tq_ff;
   logic           smem_we, tmem_we, s_rd, t_rd;

   // shared compare unit
   logic [SW-1:0]     cmp_tag_a, cmp_tag_b;
   logic [7:0]        cmp_key, cmp_probe, cmp_alt;
   tdfe_pkg::cmp_type cmp_q;

   tdfe_cmp #(.SW(SW)) u_cmp (
      .tag_a (cmp_tag_a),
      .tag_b (cmp_tag_b),
      .key   (cmp_key),
      .probe (cmp_probe),
      .alt   (cmp_alt),
      .match (cmp_q)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   // compare operands: transition entry during TSCAN, state id during SSCAN
   always_comb begin
      if (state_ff == ST_SSCAN) begin
         cmp_tag_a = '0;
         cmp_tag_b = '0;
         cmp_key   = sq_ff[15:8];
         cmp_probe = target_ff;
         cmp_alt   = target_ff;
      end else begin
         cmp_tag_a = tq_ff[TEW-1:24];
         cmp_tag_b = phase_ff ? cur_slot_ff : dflt_slot_ff;
         cmp_key   = tq_ff[23:16];
         cmp_probe = req_ff.event_id;
         cmp_alt   = default_event_ff;
      end
   end

   // sequencer
   always_comb begin
      logic       done;
      logic [2:0] r_status;
      logic [7:0] r_tact, r_eact;
      logic       issue;

      state_in     = state_ff;
      scount_in    = scount_ff;
      tcount_in    = tcount_ff;
      cur_slot_in  = cur_slot_ff;
      cur_pres_in  = cur_pres_ff;
      cur_id_in    = cur_id_ff;
      dflt_slot_in = dflt_slot_ff;
      dflt_pres_in = dflt_pres_ff;
      req_in       = req_ff;
      iss_in       = iss_ff;
      q_idx_in     = iss_ff;
      q_vld_in     = 1'b0;
      phase_in     = phase_ff;
      hit_in       = hit_ff;
      h_act_in     = h_act_ff;
      h_next_in    = h_next_ff;
      dhit_in      = dhit_ff;
      d_act_in     = d_act_ff;
      d_next_in    = d_next_ff;
      target_in    = target_ff;
      tact_in      = tact_ff;
      found_in     = found_ff;
      fslot_in     = fslot_ff;
      fentry_in    = fentry_ff;
      smem_we      = 1'b0;
      tmem_we      = 1'b0;
      s_rd         = 1'b0;
      t_rd         = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      done         = 1'b0;
      r_status     = tdfe_pkg::STATUS_OK;
      r_tact       = 8'd0;
      r_eact       = 8'd0;
      issue        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               case (req_item.kind)
                  tdfe_pkg::KIND_ADD_STATE: begin
                     done = 1'b1;
                     if (scount_ff >= SCW'(STATE_SLOTS)) begin
                        r_status = tdfe_pkg::STATUS_FULL;
                     end else begin
                        smem_we     = 1'b1;
                        cur_slot_in = scount_ff[SW-1:0];
                        cur_pres_in = 1'b1;
                        cur_id_in   = req_item.state_id;
                        if (req_item.state_id == default_state_ff) begin
                           dflt_slot_in = scount_ff[SW-1:0];
                           dflt_pres_in = 1'b1;
                        end
                        scount_in = scount_ff + 1'b1;
                     end
                  end
                  tdfe_pkg::KIND_ADD_TRANS: begin
                     done = 1'b1;
                     if (!cur_pres_ff) begin
                        r_status = tdfe_pkg::STATUS_NO_CURRENT;
                     end else if (tcount_ff >= TCW'(TRANSITION_SLOTS)) begin
                        r_status = tdfe_pkg::STATUS_FULL;
                     end else begin
                        tmem_we   = 1'b1;
                        tcount_in = tcount_ff + 1'b1;
                     end
                  end
                  tdfe_pkg::KIND_RESET: begin
                     target_in = req_item.state_id;
                     tact_in   = 8'd0;
                     found_in  = 1'b0;
                     iss_in    = '0;
                     state_in  = ST_SSCAN;
                  end
                  default: begin
                     if (!cur_pres_ff) begin
                        done     = 1'b1;
                        r_status = tdfe_pkg::STATUS_NO_CURRENT;
                     end else begin
                        hit_in   = 1'b0;
                        dhit_in  = 1'b0;
                        iss_in   = '0;
                        phase_in = !dflt_pres_ff;
                        state_in = ST_TSCAN;
                     end
                  end
               endcase
            end
         end

         ST_TSCAN: begin
            issue    = (iss_ff < CW'(tcount_ff));
            t_rd     = issue;
            q_vld_in = issue;
            if (issue) begin
               iss_in = iss_ff + 1'b1;
            end
            // last match wins within a pass
            if (q_vld_ff && cmp_q.tag_eq) begin
               if (cmp_q.key_eq) begin
                  hit_in    = 1'b1;
                  h_act_in  = tq_ff[15:8];
                  h_next_in = tq_ff[7:0];
               end else if (phase_ff && cmp_q.alt_eq) begin
                  dhit_in   = 1'b1;
                  d_act_in  = tq_ff[15:8];
                  d_next_in = tq_ff[7:0];
               end
            end
            if (!issue && !q_vld_ff) begin
               if (!phase_ff && !hit_ff) begin
                  phase_in = 1'b1;
                  iss_in   = '0;
               end else begin
                  state_in = ST_PICK;
               end
            end
         end

         ST_PICK: begin
            if (!hit_ff && !dhit_ff) begin
               done     = 1'b1;
               r_status = tdfe_pkg::STATUS_NO_MATCH;
               state_in = ST_IDLE;
            end else begin
               target_in = hit_ff ? h_next_ff : d_next_ff;
               tact_in   = hit_ff ? h_act_ff : d_act_ff;
               if ((hit_ff ? h_next_ff : d_next_ff) == cur_id_ff) begin
                  done     = 1'b1;
                  r_status = tdfe_pkg::STATUS_SAME;
                  r_tact   = hit_ff ? h_act_ff : d_act_ff;
                  state_in = ST_IDLE;
               end else begin
                  found_in = 1'b0;
                  iss_in   = '0;
                  state_in = ST_SSCAN;
               end
            end
         end

         ST_SSCAN: begin
            issue    = (iss_ff < CW'(scount_ff));
            s_rd     = issue;
            q_vld_in = issue;
            if (issue) begin
               iss_in = iss_ff + 1'b1;
            end
            if (q_vld_ff && cmp_q.key_eq) begin
               found_in  = 1'b1;
               fslot_in  = q_idx_ff[SW-1:0];
               fentry_in = sq_ff[7:0];
            end
            if (!issue && !q_vld_ff) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               r_tact   = tact_ff;
               if (found_ff) begin
                  cur_slot_in = fslot_ff;
                  cur_pres_in = 1'b1;
                  cur_id_in   = target_ff;
                  r_eact      = fentry_ff;
               end else if (req_ff.kind == tdfe_pkg::KIND_RESET) begin
                  r_status = tdfe_pkg::STATUS_RESET_MISSING;
               end else begin
                  r_status = tdfe_pkg::STATUS_NEXT_MISSING;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rsp_valid_in                  = 1'b1;
         rsp_item_in.status            = r_status;
         rsp_item_in.transition_action = r_tact;
         rsp_item_in.entry_action      = r_eact;
         rsp_item_in.current_state     = cur_pres_in ? cur_id_in : 8'd0;
         rsp_item_in.current_valid     = cur_pres_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scount_ff        <= '0;
         tcount_ff        <= '0;
         cur_slot_ff      <= '0;
         cur_pres_ff      <= 1'b0;
         dflt_slot_ff     <= '0;
         dflt_pres_ff     <= 1'b0;
         q_vld_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         default_state_ff <= 8'hFF;
         default_event_ff <= 8'hFF;
      end else begin
         state_ff     <= state_in;
         scount_ff    <= scount_in;
         tcount_ff    <= tcount_in;
         cur_slot_ff  <= cur_slot_in;
         cur_pres_ff  <= cur_pres_in;
         dflt_slot_ff <= dflt_slot_in;
         dflt_pres_ff <= dflt_pres_in;
         q_vld_ff     <= q_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tdfe_pkg::CSR_DEFAULT_STATE: default_state_ff <= csr_wdata;
               tdfe_pkg::CSR_DEFAULT_EVENT: default_event_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_id_ff   <= cur_id_in;
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      q_idx_ff    <= q_idx_in;
      phase_ff    <= phase_in;
      hit_ff      <= hit_in;
      h_act_ff    <= h_act_in;
      h_next_ff   <= h_next_in;
      dhit_ff     <= dhit_in;
      d_act_ff    <= d_act_in;
      d_next_ff   <= d_next_in;
      target_ff   <= target_in;
      tact_ff     <= tact_in;
      found_ff    <= found_in;
      fslot_ff    <= fslot_in;
      fentry_ff   <= fentry_in;
      rsp_item_ff <= rsp_item_in;
   end

   // state table: {id, entry action}
   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[scount_ff[SW-1:0]] <= {req_item.state_id, req_item.action_id};
      end
      if (s_rd) begin
         sq_ff <= smem[iss_ff[SW-1:0]];
      end
   end

   // transition table: {owner slot, event, action, next id}
   always_ff @(posedge clock) begin
      if (tmem_we) begin
         tmem[tcount_ff[TW-1:0]] <= {cur_slot_ff, req_item.event_id,
                                     req_item.action_id, req_item.next_state_id};
      end
      if (t_rd) begin
         tq_ff <= tmem[iss_ff[TW-1:0]];
      end
   end

endmodule

`default_nettype wire

FILE: sv/tdfe_checker.sv
// Port-level checker for table_driven_fsm_engine, bound to the top level.
// Uses tdfe_pkg.
`default_nettype none

module tdfe_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire tdfe_pkg::rsp_type rsp_item
);

   // an accepted request either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

   // leaving busy always delivers the response
   a_done_responds: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // one request, one response
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !start) |=> !rsp_valid)
      else $error("response repeated without a new request");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status <= tdfe_pkg::STATUS_NO_CURRENT))
      else $error("status code out of range");

   a_no_current_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.current_valid) |-> (rsp_item.current_state == 8'd0))
      else $error("current_state nonzero without a current state");

endmodule

bind table_driven_fsm_engine tdfe_checker u_tdfe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: tb/table_driven_fsm_engine_test.sv
// Self-checking testbench for table_driven_fsm_engine: directed and random requests,
// each response checked against a behavioral model of the state machine tables.
// Depends on tdfe_pkg and the engine RTL.
`default_nettype none

module table_driven_fsm_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Run limit, far above the slowest legal run (~500 requests).
   localparam int RUN_LIMIT_NS = 3_000_000;
   // Latency guard at the end: a bit more than the worst-case event scan.
   localparam int TAIL_CYCLES  = 200;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           start     = 1'b0;
   logic                           busy;
   tdfe_pkg::req_type              req_item  = '0;
   logic                           rsp_valid;
   tdfe_pkg::rsp_type              rsp_item;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tdfe_pkg::CSR_IDX_W-1:0] csr_index = tdfe_pkg::CSR_DEFAULT_STATE;
   logic [7:0]                     csr_wdata = '0;

   table_driven_fsm_engine uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Behavioral copy of the engine: state table, transition table,
   // fill counts, current / default state pointers and the two registers.
   // ------------------------------------------------------------------
   logic [7:0] fsm_state_id    [tdfe_pkg::STATE_SLOTS_DEF];
   logic [7:0] fsm_state_entry [tdfe_pkg::STATE_SLOTS_DEF];
   int         fsm_tr_owner    [tdfe_pkg::TRANSITION_SLOTS_DEF];
   logic [7:0] fsm_tr_event    [tdfe_pkg::TRANSITION_SLOTS_DEF];
   logic [7:0] fsm_tr_action   [tdfe_pkg::TRANSITION_SLOTS_DEF];
   logic [7:0] fsm_tr_next     [tdfe_pkg::TRANSITION_SLOTS_DEF];
   int         fsm_state_cnt   = 0;
   int         fsm_tr_cnt      = 0;
   int         fsm_cur_slot    = 0;
   bit         fsm_cur_valid   = 1'b0;
   int         fsm_def_slot    = 0;
   bit         fsm_def_valid   = 1'b0;
   logic [7:0] cfg_default_state = 8'hFF;
   logic [7:0] cfg_default_event = 8'hFF;

   tdfe_pkg::rsp_type expected_rsps[$];
   int                mismatch_count = 0;

   // Last added state carrying this id, -1 when there is none.
   function automatic int find_state_slot(input logic [7:0] id);
      int slot;
      slot = -1;
      for (int i = 0; i < fsm_state_cnt; i++)
         if (fsm_state_id[i] == id) slot = i;
      return slot;
   endfunction

   // Applies one accepted request to the model and returns the response it owes.
   function automatic tdfe_pkg::rsp_type predict_response(input tdfe_pkg::req_type r);
      tdfe_pkg::rsp_type p;
      int      hit_idx, dflt_idx, slot;
      bit      hit, dhit;
      p = '0;
      p.status = tdfe_pkg::STATUS_OK;
      case (r.kind)
         tdfe_pkg::KIND_ADD_STATE: begin
            if (fsm_state_cnt >= tdfe_pkg::STATE_SLOTS_DEF) begin
               p.status = tdfe_pkg::STATUS_FULL;
            end else begin
               fsm_state_id[fsm_state_cnt]    = r.state_id;
               fsm_state_entry[fsm_state_cnt] = r.action_id;
               fsm_cur_slot  = fsm_state_cnt;
               fsm_cur_valid = 1'b1;
               // default pointer is latched here; later register writes do not move it
               if (r.state_id == cfg_default_state) begin
                  fsm_def_slot  = fsm_state_cnt;
                  fsm_def_valid = 1'b1;
               end
               fsm_state_cnt++;
            end
         end
         tdfe_pkg::KIND_ADD_TRANS: begin
            if (!fsm_cur_valid) begin
               p.status = tdfe_pkg::STATUS_NO_CURRENT;
            end else if (fsm_tr_cnt >= tdfe_pkg::TRANSITION_SLOTS_DEF) begin
               p.status = tdfe_pkg::STATUS_FULL;
            end else begin
               fsm_tr_owner[fsm_tr_cnt]  = fsm_cur_slot;
               fsm_tr_event[fsm_tr_cnt]  = r.event_id;
               fsm_tr_action[fsm_tr_cnt] = r.action_id;
               fsm_tr_next[fsm_tr_cnt]   = r.next_state_id;
               fsm_tr_cnt++;
            end
         end
         tdfe_pkg::KIND_RESET: begin
            slot = find_state_slot(r.state_id);
            if (slot >= 0) begin
               fsm_cur_slot   = slot;
               fsm_cur_valid  = 1'b1;
               p.entry_action = fsm_state_entry[slot];
            end else begin
               p.status = tdfe_pkg::STATUS_RESET_MISSING;
            end
         end
         default: begin
            if (!fsm_cur_valid) begin
               p.status = tdfe_pkg::STATUS_NO_CURRENT;
            end else begin
               hit = 1'b0;
               dhit = 1'b0;
               hit_idx = 0;
               dflt_idx = 0;
               // default state's transitions take priority; last match wins
               if (fsm_def_valid)
                  for (int i = 0; i < fsm_tr_cnt; i++)
                     if (fsm_tr_owner[i] == fsm_def_slot && fsm_tr_event[i] == r.event_id) begin
                        hit_idx = i;
                        hit = 1'b1;
                     end
               // then the current state's own, remembering any default-event entry
               if (!hit)
                  for (int i = 0; i < fsm_tr_cnt; i++) begin
                     if (fsm_tr_owner[i] == fsm_cur_slot) begin
                        if (fsm_tr_event[i] == r.event_id) begin
                           hit_idx = i;
                           hit = 1'b1;
                        end else if (fsm_tr_event[i] == cfg_default_event) begin
                           dflt_idx = i;
                           dhit = 1'b1;
                        end
                     end
                  end
               if (!hit && dhit) begin
                  hit_idx = dflt_idx;
                  hit = 1'b1;
               end
               if (!hit) begin
                  p.status = tdfe_pkg::STATUS_NO_MATCH;
               end else begin
                  p.transition_action = fsm_tr_action[hit_idx];
                  if (fsm_tr_next[hit_idx] == fsm_state_id[fsm_cur_slot]) begin
                     p.status = tdfe_pkg::STATUS_SAME;
                  end else begin
                     slot = find_state_slot(fsm_tr_next[hit_idx]);
                     if (slot >= 0) begin
                        fsm_cur_slot   = slot;
                        p.entry_action = fsm_state_entry[slot];
                     end else begin
                        p.status = tdfe_pkg::STATUS_NEXT_MISSING;
                     end
                  end
               end
            end
         end
      endcase
      p.current_state = fsm_cur_valid ? fsm_state_id[fsm_cur_slot] : 8'h00;
      p.current_valid = fsm_cur_valid;
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Response checker. A response is valid for one cycle only and cannot
   // be held off, so it is taken at every edge where rsp_valid was high.
   // Values read right after the edge are the pre-edge ones.
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: response %s mismatch, expected %0d, actual %0d",
                  $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_checker
      tdfe_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_item);
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_item.status));
            check_field("transition_action", 32'(want.transition_action),
                        32'(rsp_item.transition_action));
            check_field("entry_action", 32'(want.entry_action),
                        32'(rsp_item.entry_action));
            check_field("current_state", 32'(want.current_state),
                        32'(rsp_item.current_state));
            check_field("current_valid", 32'(want.current_valid),
                        32'(rsp_item.current_valid));
         end
      end
   end

   // ------------------------------------------------------------------
   // Request driver. Called at a rising-edge time step. start is left high
   // after acceptance so back-to-back requests never drop it for a step;
   // callers that stop sending lower it (see wait_engine_idle).
   // idle_pct is the per-cycle chance of an idle cycle before the request;
   // in idle phases the request is sometimes also held until the engine
   // has gone idle, so start arrives at every point of its work.
   // ------------------------------------------------------------------
   task automatic send_request(input tdfe_pkg::req_type r, input int idle_pct);
      int gap;
      bit late;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
      late = (idle_pct != 0) && ($urandom_range(7) == 0);
      if (gap != 0 || late) start <= 1'b0;
      if (late) begin
         do @(posedge clock); while (busy);
      end
      repeat (gap) @(posedge clock);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(predict_response(r));
   endtask

   // Drop start and wait until every owed response is in and busy is low.
   // Every request owes exactly one response, so nothing is left running.
   task automatic wait_engine_idle();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0 || busy);
   endtask

   // Writes both registers back to back; valid stays high between them.
   task automatic set_config(input logic [7:0] dflt_state, input logic [7:0] dflt_event);
      csr_valid <= 1'b1;
      csr_index <= tdfe_pkg::CSR_DEFAULT_STATE;
      csr_wdata <= dflt_state;
      do @(posedge clock); while (!csr_ready);
      cfg_default_state = dflt_state;
      csr_index <= tdfe_pkg::CSR_DEFAULT_EVENT;
      csr_wdata <= dflt_event;
      do @(posedge clock); while (!csr_ready);
      cfg_default_event = dflt_event;
      csr_valid <= 1'b0;
   endtask

   function automatic tdfe_pkg::req_type make_req(input logic [1:0] kind,
                                                  input logic [7:0] sid,
                                                  input logic [7:0] ev, input logic [7:0] act,
                                                  input logic [7:0] nxt);
      tdfe_pkg::req_type r;
      r.kind          = kind;
      r.state_id      = sid;
      r.event_id      = ev;
      r.action_id     = act;
      r.next_state_id = nxt;
      return r;
   endfunction

   // Mostly ids that exist in the tables, so resets and transitions land.
   function automatic logic [7:0] pick_state_id();
      if (fsm_state_cnt > 0 && $urandom_range(99) < 55)
         return fsm_state_id[$urandom_range(fsm_state_cnt - 1)];
      if ($urandom_range(99) < 30) return cfg_default_state;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_event_id();
      if (fsm_tr_cnt > 0 && $urandom_range(99) < 45)
         return fsm_tr_event[$urandom_range(fsm_tr_cnt - 1)];
      if ($urandom_range(99) < 30) return cfg_default_event;
      if ($urandom_range(99) < 50) return 8'($urandom_range(3));
      return 8'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty machine: no current state yet, and no states to reset to.
   task automatic test_no_current();
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h00, 8'hFF, 8'hFF), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'hFF, 8'hFF, 8'h00, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_RESET,     8'h00, 8'h5A, 8'hA5, 8'h3C), 0);
   endtask

   // Hand-built machine, run with default_state 0 and default_event 0xFF.
   task automatic test_directed_transitions();
      // state 0 becomes the default state too
      send_request(make_req(tdfe_pkg::KIND_ADD_STATE, 8'h00, 8'h00, 8'h11, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h01, 8'hA1, 8'hFF), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_STATE, 8'hFF, 8'h00, 8'hFF, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h02, 8'hB2, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'hFF, 8'hC3, 8'hFF), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h01, 8'h77, 8'h00), 0);
      // default state's event 1 beats the current state's event 1; lands on itself
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h01, 8'h00, 8'h00), 0);
      // plain transition into state 0, entry action reported
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h02, 8'h00, 8'h00), 0);
      // nothing matches in state 0
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h09, 8'h00, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_RESET,     8'hFF, 8'h00, 8'h00, 8'h00), 0);
      // falls back to the default-event entry
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h55, 8'h00, 8'h00), 0);
      // event equal to default_event takes the entry directly
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'hFF, 8'h00, 8'h00), 0);
      // target never added: action reported, state kept
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h03, 8'h33, 8'h42), 0);
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h03, 8'h00, 8'h00), 0);
      // two entries for the same event: the later one wins
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h04, 8'h40, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'h00, 8'h04, 8'h44, 8'hFF), 0);
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h04, 8'h00, 8'h00), 0);
      // duplicate id: lookups by id find the newer slot
      send_request(make_req(tdfe_pkg::KIND_ADD_STATE, 8'hFF, 8'h00, 8'h5A, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_RESET,     8'h00, 8'h00, 8'h00, 8'h00), 0);
      send_request(make_req(tdfe_pkg::KIND_RESET,     8'hFF, 8'h00, 8'h00, 8'h00), 0);
      // newer 0xFF slot owns no transitions
      send_request(make_req(tdfe_pkg::KIND_EVENT,     8'h00, 8'h02, 8'h00, 8'h00), 0);
   endtask

   // Random traffic: mostly well-formed requests using live ids, some noise.
   // Fields a kind does not use carry random bits.
   task automatic test_random_traffic(input int n_items, input int idle_pct);
      tdfe_pkg::req_type r;
      int      roll;
      for (int i = 0; i < n_items; i++) begin
         r = make_req(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         if ($urandom_range(99) >= 10) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               r.kind     = tdfe_pkg::KIND_ADD_STATE;
               r.state_id = pick_state_id();
            end else if (roll < 22) begin
               r.kind          = tdfe_pkg::KIND_ADD_TRANS;
               r.event_id      = pick_event_id();
               r.next_state_id = ($urandom_range(99) < 75) ? pick_state_id() : 8'($urandom);
            end else if (roll < 37) begin
               r.kind     = tdfe_pkg::KIND_RESET;
               r.state_id = pick_state_id();
            end else begin
               r.kind     = tdfe_pkg::KIND_EVENT;
               r.event_id = pick_event_id();
            end
         end
         send_request(r, idle_pct);
      end
   endtask

   // Fill both tables and push past the end of each.
   task automatic test_table_full(input int idle_pct);
      int n_adds;
      n_adds = tdfe_pkg::STATE_SLOTS_DEF - fsm_state_cnt + 2;
      for (int i = 0; i < n_adds; i++)
         send_request(make_req(tdfe_pkg::KIND_ADD_STATE, pick_state_id(), 8'($urandom),
                               8'($urandom), 8'($urandom)), idle_pct);
      n_adds = tdfe_pkg::TRANSITION_SLOTS_DEF - fsm_tr_cnt + 2;
      for (int i = 0; i < n_adds; i++)
         send_request(make_req(tdfe_pkg::KIND_ADD_TRANS, 8'($urandom), pick_event_id(),
                               8'($urandom), pick_state_id()), idle_pct);
   endtask

   // ------------------------------------------------------------------
   // Sequence. Register writes happen only with the engine idle.
   // ------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_config(8'h00, 8'hFF);
      test_no_current();
      test_directed_transitions();

      wait_engine_idle();
      set_config(8'hFF, 8'h00);
      test_random_traffic(100, 0);

      wait_engine_idle();
      set_config(8'($urandom), 8'($urandom));
      test_random_traffic(100, 68);

      wait_engine_idle();
      set_config(8'h00, 8'h00);
      test_table_full(6);
      test_random_traffic(100, 6);

      wait_engine_idle();
      set_config(8'($urandom), 8'hFF);
      test_random_traffic(100, 68);

      wait_engine_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: table_driven_fsm_engine.f
sv/tdfe_pkg.sv
sv/tdfe_cmp.sv
sv/table_driven_fsm_engine.sv
sv/tdfe_checker.sv
tb/table_driven_fsm_engine_test.sv
